// ===== src/hpc_pkg.sv =====
// Shared constants for the hit polar coordinate pipeline.
// CORDIC arctangent table in 32-bit binary turns; no dependencies.
package hpc_pkg;

  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned CORDIC_W     = 64;
  localparam int unsigned TURN_W       = 32;
  localparam int unsigned SCALE_BITS   = 60;

  localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;

  localparam logic [TURN_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

endpackage

// ===== src/hpc_in_if.sv =====
// Input channel: point and reference coordinates with valid/ready.
// No dependencies.
interface hpc_in_if #(parameter int COORD_BITS = 18);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic signed [COORD_BITS-1:0] pz;
  logic signed [COORD_BITS-1:0] rx;
  logic signed [COORD_BITS-1:0] ry;
  logic signed [COORD_BITS-1:0] rz;

  modport source (output valid, px, py, pz, rx, ry, rz, input ready);
  modport sink   (input valid, px, py, pz, rx, ry, rz, output ready);
endinterface

// ===== src/hpc_out_if.sv =====
// Output channel: radii and azimuth angles with valid/ready.
// No dependencies.
interface hpc_out_if #(parameter int COORD_BITS = 18, parameter int ANGLE_BITS = 16);
  logic valid;
  logic ready;
  logic        [COORD_BITS-1:0] radius_3d;
  logic        [COORD_BITS-1:0] radius_t;
  logic        [ANGLE_BITS-1:0] azimuth;
  logic signed [ANGLE_BITS-1:0] delta_azimuth;
  logic signed [ANGLE_BITS-1:0] azimuth_change;

  modport source (output valid, radius_3d, radius_t, azimuth, delta_azimuth,
                  azimuth_change, input ready);
  modport sink   (input valid, radius_3d, radius_t, azimuth, delta_azimuth,
                  azimuth_change, output ready);
endinterface

// ===== src/hit_polar_coords_delta_phi.sv =====
// Polar coordinates of a hit with azimuth differences to a reference point.
// Square root chains run beside 30 CORDIC cells per vector; delay lines align them.
// Throughput: one item per cycle; the whole pipeline holds only while the output
// register is full and not taken.
// Reset clears the valid bits; data registers are not reset.
module hit_polar_coords_delta_phi #(
  parameter int COORD_BITS = 18,
  parameter int ANGLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  hpc_in_if.sink    hits,
  hpc_out_if.source coords
);
  import hpc_pkg::*;

  localparam int CB       = COORD_BITS;
  localparam int SW       = 2 * CB + 2;
  localparam int SQ       = CB + 1;
  localparam int PRESHIFT = SCALE_BITS - CB;
  localparam int NSTEP    = CORDIC_STEPS;
  localparam int D        = (NSTEP > SQ + 1) ? NSTEP : SQ + 1;
  localparam int PAD_C    = D - NSTEP;
  localparam int PAD_S    = D - SQ - 1;
  localparam int NV       = D + 3;
  localparam logic [TURN_W-1:0] HALF_ANG = TURN_W'(1) << (TURN_W - 1 - ANGLE_BITS);

  logic          en;
  logic [NV-1:0] vld;

  assign en         = !vld[NV-1] || coords.ready;
  assign hits.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], hits.valid};
    end
  end

  // Stage A: capture and form the difference vector
  logic signed [CB-1:0] a_px, a_py, a_pz;
  logic signed [CB:0]   a_vx [3];
  logic signed [CB:0]   a_vy [3];

  always_ff @(posedge clk) begin
    if (en) begin
      a_px    <= hits.px;
      a_py    <= hits.py;
      a_pz    <= hits.pz;
      a_vx[0] <= (CB+1)'(hits.px);
      a_vy[0] <= (CB+1)'(hits.py);
      a_vx[1] <= (CB+1)'(hits.rx);
      a_vy[1] <= (CB+1)'(hits.ry);
      a_vx[2] <= (CB+1)'(hits.px) - (CB+1)'(hits.rx);
      a_vy[2] <= (CB+1)'(hits.py) - (CB+1)'(hits.ry);
    end
  end

  // Stage B: squares, and fold vectors into the right half plane
  logic [CB:0]   ax, ay, az;
  logic [SW-1:0] b_sqx, b_sqy, b_sqz;

  assign ax = a_px[CB-1] ? (CB+1)'(-(CB+1)'(a_px)) : (CB+1)'(a_px);
  assign ay = a_py[CB-1] ? (CB+1)'(-(CB+1)'(a_py)) : (CB+1)'(a_py);
  assign az = a_pz[CB-1] ? (CB+1)'(-(CB+1)'(a_pz)) : (CB+1)'(a_pz);

  logic signed [CORDIC_W-1:0] prep_x [3];
  logic signed [CORDIC_W-1:0] prep_y [3];
  logic        [TURN_W-1:0]   prep_z [3];
  logic        [2:0]          prep_zero;

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      prep_zero[v] = (a_vx[v] == '0) && (a_vy[v] == '0);
      if (a_vx[v] < 0) begin
        prep_x[v] = (-CORDIC_W'(a_vx[v])) <<< PRESHIFT;
        prep_y[v] = (-CORDIC_W'(a_vy[v])) <<< PRESHIFT;
        prep_z[v] = HALF_TURN;
      end else begin
        prep_x[v] = CORDIC_W'(a_vx[v]) <<< PRESHIFT;
        prep_y[v] = CORDIC_W'(a_vy[v]) <<< PRESHIFT;
        prep_z[v] = '0;
      end
    end
  end

  logic signed [CORDIC_W-1:0] cx [3][NSTEP+1];
  logic signed [CORDIC_W-1:0] cy [3][NSTEP+1];
  logic        [TURN_W-1:0]   cz [3][NSTEP+1];
  logic signed [CORDIC_W-1:0] ld_x [3];
  logic signed [CORDIC_W-1:0] ld_y [3];
  logic        [TURN_W-1:0]   ld_z [3];
  logic        [2:0]          b_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      b_sqx  <= SW'(ax * ax);
      b_sqy  <= SW'(ay * ay);
      b_sqz  <= SW'(az * az);
      b_zero <= prep_zero;
      for (int v = 0; v < 3; v++) begin
        ld_x[v] <= prep_x[v];
        ld_y[v] <= prep_y[v];
        ld_z[v] <= prep_z[v];
      end
    end
  end

  // CORDIC chains: point, reference, difference
  genvar gv, gi;
  generate
    for (gv = 0; gv < 3; gv++) begin : g_vec
      assign cx[gv][0] = ld_x[gv];
      assign cy[gv][0] = ld_y[gv];
      assign cz[gv][0] = ld_z[gv];
      for (gi = 0; gi < NSTEP; gi++) begin : g_cell
        hpc_cordic_cell #(.IDX(gi)) u_cell (
          .clk   (clk),
          .en    (en),
          .x_in  (cx[gv][gi]),
          .y_in  (cy[gv][gi]),
          .z_in  (cz[gv][gi]),
          .x_out (cx[gv][gi+1]),
          .y_out (cy[gv][gi+1]),
          .z_out (cz[gv][gi+1])
        );
      end
    end
  endgenerate

  logic [2:0] zero_d;
  hpc_delay #(.W(3), .DEPTH(NSTEP)) u_zero_dly (
    .clk (clk), .en (en), .d (b_zero), .q (zero_d)
  );

  logic [3*TURN_W-1:0] phi_cat, phi_dly;
  assign phi_cat = {zero_d[2] ? TURN_W'(0) : cz[2][NSTEP],
                    zero_d[1] ? TURN_W'(0) : cz[1][NSTEP],
                    zero_d[0] ? TURN_W'(0) : cz[0][NSTEP]};

  hpc_delay #(.W(3*TURN_W), .DEPTH(PAD_C)) u_phi_dly (
    .clk (clk), .en (en), .d (phi_cat), .q (phi_dly)
  );

  // Square root chains: transverse and 3D
  logic [SW-1:0] rem_t [SQ+1];
  logic [SW-1:0] rt_t  [SQ+1];
  logic [SW-1:0] rem_3 [SQ+1];
  logic [SW-1:0] rt_3  [SQ+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_t[0] <= b_sqx + b_sqy;
      rem_3[0] <= b_sqx + b_sqy + b_sqz;
      rt_t[0]  <= '0;
      rt_3[0]  <= '0;
    end
  end

  genvar gk;
  generate
    for (gk = 0; gk < SQ; gk++) begin : g_sqrt
      hpc_sqrt_cell #(.SW(SW), .K(SQ - 1 - gk)) u_t (
        .clk (clk), .en (en),
        .rem_in (rem_t[gk]), .root_in (rt_t[gk]),
        .rem_out (rem_t[gk+1]), .root_out (rt_t[gk+1])
      );
      hpc_sqrt_cell #(.SW(SW), .K(SQ - 1 - gk)) u_3 (
        .clk (clk), .en (en),
        .rem_in (rem_3[gk]), .root_in (rt_3[gk]),
        .rem_out (rem_3[gk+1]), .root_out (rt_3[gk+1])
      );
    end
  endgenerate

  // Round to nearest: bump when the remainder exceeds the root
  logic [SW-1:0]   rnd_t, rnd_3;
  logic [2*CB-1:0] rad_cat, rad_dly;
  assign rnd_t   = rt_t[SQ] + SW'(rem_t[SQ] > rt_t[SQ]);
  assign rnd_3   = rt_3[SQ] + SW'(rem_3[SQ] > rt_3[SQ]);
  assign rad_cat = {rnd_3[CB-1:0], rnd_t[CB-1:0]};

  hpc_delay #(.W(2*CB), .DEPTH(PAD_S)) u_rad_dly (
    .clk (clk), .en (en), .d (rad_cat), .q (rad_dly)
  );

  // Output stage: differences and rounding to the output angle width
  logic [TURN_W-1:0] phi_p, phi_r, phi_d;
  logic [TURN_W-1:0] rn_a, rn_d, rn_c;

  assign phi_p = phi_dly[TURN_W-1:0];
  assign phi_r = phi_dly[2*TURN_W-1:TURN_W];
  assign phi_d = phi_dly[3*TURN_W-1:2*TURN_W];
  assign rn_a  = phi_p + HALF_ANG;
  assign rn_d  = phi_p - phi_r + HALF_ANG;
  assign rn_c  = phi_d - phi_r + HALF_ANG;

  always_ff @(posedge clk) begin
    if (en) begin
      coords.radius_t       <= rad_dly[CB-1:0];
      coords.radius_3d      <= rad_dly[2*CB-1:CB];
      coords.azimuth        <= rn_a[TURN_W-1 -: ANGLE_BITS];
      coords.delta_azimuth  <= rn_d[TURN_W-1 -: ANGLE_BITS];
      coords.azimuth_change <= rn_c[TURN_W-1 -: ANGLE_BITS];
    end
  end

  assign coords.valid = vld[NV-1];

endmodule

// ===== src/hpc_delay.sv =====
// Enable-gated register delay line used to align pipeline branches.
// No dependencies.
module hpc_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  generate
    if (DEPTH == 0) begin : g_none
      assign q = d;
    end else begin : g_line
      logic [W-1:0] taps [DEPTH];
      always_ff @(posedge clk) begin
        if (en) begin
          taps[0] <= d;
          for (int i = 1; i < DEPTH; i++) begin
            taps[i] <= taps[i-1];
          end
        end
      end
      assign q = taps[DEPTH-1];
    end
  endgenerate

endmodule

// ===== src/hpc_cordic_cell.sv =====
// One vectoring CORDIC micro-rotation, registered.
// Depends on hpc_pkg for the arctangent table.
module hpc_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [hpc_pkg::CORDIC_W-1:0] x_in,
  input  logic signed [hpc_pkg::CORDIC_W-1:0] y_in,
  input  logic        [hpc_pkg::TURN_W-1:0]   z_in,
  output logic signed [hpc_pkg::CORDIC_W-1:0] x_out,
  output logic signed [hpc_pkg::CORDIC_W-1:0] y_out,
  output logic        [hpc_pkg::TURN_W-1:0]   z_out
);
  import hpc_pkg::*;

  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;

  assign xs = x_in >>> IDX;
  assign ys = y_in >>> IDX;

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in < 0) begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ATAN_TURNS[IDX];
      end else begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ATAN_TURNS[IDX];
      end
    end
  end

endmodule

// ===== src/hpc_sqrt_cell.sv =====
// One digit of a restoring integer square root, registered.
// No dependencies.
module hpc_sqrt_cell #(
  parameter int SW = 38,
  parameter int K  = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [SW-1:0] rem_in,
  input  logic [SW-1:0] root_in,
  output logic [SW-1:0] rem_out,
  output logic [SW-1:0] root_out
);

  localparam logic [SW-1:0] BIT = SW'(1) << (2 * K);

  logic [SW-1:0] trial;
  assign trial = root_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_in >= trial) begin
        rem_out  <= rem_in - trial;
        root_out <= (root_in >> 1) + BIT;
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in >> 1;
      end
    end
  end

endmodule

// ===== sim/hpc_tb_if.sv =====
// Testbench copies are not needed; the RTL interfaces in src are used directly.
// This file holds the shared scoreboard record type; depends on nothing.
package hpc_tb_pkg;
  typedef struct packed {
    logic [17:0] radius_3d;
    logic [17:0] radius_t;
    logic [15:0] azimuth;
    logic [15:0] delta_azimuth;
    logic [15:0] azimuth_change;
  } coords_t;
endpackage

// ===== sim/hit_polar_coords_delta_phi_tb.sv =====
// Testbench for hit_polar_coords_delta_phi: drives hits through hpc_in_if,
// predicts radii and CORDIC azimuths, checks hpc_out_if. Uses hpc_pkg, hpc_tb_pkg.
module hit_polar_coords_delta_phi_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hpc_pkg::*;
  import hpc_tb_pkg::*;

  localparam int CB = 18;
  localparam int AB = 16;
  localparam int LATENCY = 33;
  localparam longint LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  hpc_in_if  #(.COORD_BITS(CB)) hits ();
  hpc_out_if #(.COORD_BITS(CB), .ANGLE_BITS(AB)) coords ();

  hit_polar_coords_delta_phi #(.COORD_BITS(CB), .ANGLE_BITS(AB)) dut (
    .clk(clk), .rst(rst), .hits(hits.sink), .coords(coords.source)
  );

  coords_t expected_coords[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("hit_polar_coords_delta_phi_tb: errors");
      $finish;
    end
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] turn_of(longint x, longint y);
    logic [31:0] z;
    longint xs, ys;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    x = x <<< (SCALE_BITS - CB);
    y = y <<< (SCALE_BITS - CB);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y < 0) begin
        x -= ys;
        y += xs;
        z -= ATAN_TURNS[i];
      end else begin
        x += ys;
        y -= xs;
        z += ATAN_TURNS[i];
      end
    end
    return z;
  endfunction

  function automatic logic [AB-1:0] narrow_angle(logic [31:0] a);
    logic [31:0] r;
    r = a + (32'd1 << (31 - AB));
    return r[31:32-AB];
  endfunction

  function automatic logic [CB-1:0] nearest_root(longint unsigned n);
    longint unsigned r, lo, hi, m;
    lo = 0;
    hi = 64'd1 << 32;
    while (hi - lo > 1) begin
      m = (lo + hi) / 2;
      if (m * m <= n) lo = m; else hi = m;
    end
    r = lo;
    if (n - r * r > r) r++;
    return r[CB-1:0];
  endfunction

  function automatic coords_t predict_coords(logic signed [CB-1:0] px, py, pz, rx, ry);
    coords_t c;
    longint x, y, z, sum_t;
    logic [31:0] phi_p, phi_r, phi_d;
    x = longint'(px);
    y = longint'(py);
    z = longint'(pz);
    sum_t = x * x + y * y;
    phi_p = turn_of(x, y);
    phi_r = turn_of(longint'(rx), longint'(ry));
    phi_d = turn_of(x - longint'(rx), y - longint'(ry));
    c.radius_3d = nearest_root(sum_t + z * z);
    c.radius_t = nearest_root(sum_t);
    c.azimuth = narrow_angle(phi_p);
    c.delta_azimuth = narrow_angle(phi_p - phi_r);
    c.azimuth_change = narrow_angle(phi_d - phi_r);
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // receiver: stall at random or during a hold-off stretch
  initial coords.ready = 1'b0;
  always @(negedge clk) begin
    if (hold_off > 0) begin
      coords.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      coords.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    coords_t want;
    if (!rst && coords.valid && coords.ready) begin
      if (expected_coords.size() == 0) begin
        report_mismatch("unexpected result transfer", 1, 0);
      end else begin
        want = expected_coords.pop_front();
        if (coords.radius_3d !== want.radius_3d)
          report_mismatch("radius_3d", longint'(coords.radius_3d),
                          longint'(want.radius_3d));
        if (coords.radius_t !== want.radius_t)
          report_mismatch("radius_t", longint'(coords.radius_t),
                          longint'(want.radius_t));
        if (coords.azimuth !== want.azimuth)
          report_mismatch("azimuth", longint'(coords.azimuth), longint'(want.azimuth));
        if (coords.delta_azimuth !== want.delta_azimuth)
          report_mismatch("delta_azimuth", longint'($signed(coords.delta_azimuth)),
                          longint'($signed(want.delta_azimuth)));
        if (coords.azimuth_change !== want.azimuth_change)
          report_mismatch("azimuth_change", longint'($signed(coords.azimuth_change)),
                          longint'($signed(want.azimuth_change)));
      end
    end
  end

  // offer one hit, hold until the transfer, record the prediction
  task automatic send_hit(logic signed [CB-1:0] px, py, pz, rx, ry, rz);
    while ($urandom_range(99) < send_idle_pct) begin
      hits.valid <= 1'b0;
      @(negedge clk);
    end
    hits.valid <= 1'b1;
    hits.px <= px;
    hits.py <= py;
    hits.pz <= pz;
    hits.rx <= rx;
    hits.ry <= ry;
    hits.rz <= rz;
    do @(posedge clk); while (!hits.ready);
    expected_coords.push_back(predict_coords(px, py, pz, rx, ry));
    @(negedge clk);
  endtask

  function automatic logic signed [CB-1:0] any_coord();
    case ($urandom_range(9))
      0: return CB'(-(1 <<< (CB - 1)));
      1: return CB'((1 <<< (CB - 1)) - 1);
      2: return CB'($signed(CB'($urandom_range(6))) - 3);
      3: return CB'($signed(CB'($urandom_range(255))) - 128);
      default: return CB'($urandom);
    endcase
  endfunction

  // drop valid and wait until every expected result has come
  task automatic drain();
    hits.valid <= 1'b0;
    while (expected_coords.size() != 0) @(negedge clk);
  endtask

  task automatic test_extremes();
    logic signed [CB-1:0] mn, mx;
    mn = CB'(-(1 <<< (CB - 1)));
    mx = CB'((1 <<< (CB - 1)) - 1);
    send_hit(0, 0, 0, 0, 0, 0);         // origin everywhere
    send_hit(mx, mx, mx, mn, mn, mx);   // widest P - R
    send_hit(mn, mn, mn, mx, mx, mn);
    send_hit(mn, 0, 0, 0, 0, 0);
    send_hit(mx, 0, mn, mn, 0, 0);
    send_hit(0, mx, 0, 0, mn, 0);
    send_hit(1, 0, 0, -1, 0, 0);        // exactly half a turn apart
    send_hit(0, 1, 0, 0, -1, 0);
    send_hit(5, 0, 3, 5, 0, 0);         // P and R share x and y: P - R at origin
    send_hit(100, -1, 0, 0, 0, 0);      // just below a full turn
    send_hit(mx, -1, 0, 1, 0, 0);
    send_hit(-1, -1, -1, 1, 1, 1);
    send_hit(3, 4, 12, -3, 4, 0);
    send_hit(mn, mx, 7, mx, mn, 0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_hit(any_coord(), any_coord(), any_coord(),
               any_coord(), any_coord(), any_coord());
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    test_random(80);                    // block fills and stalls its input
    drain();
    test_random(20);
  endtask

  initial begin
    hits.valid = 1'b0;
    hits.px = '0; hits.py = '0; hits.pz = '0;
    hits.rx = '0; hits.ry = '0; hits.rz = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_random(350);
    send_idle_pct = 57;
    test_random(350);
    send_idle_pct = 0;
    recv_stall_pct = 57;
    test_random(350);
    send_idle_pct = 17;
    recv_stall_pct = 17;
    test_random(350);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    drain();
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0 && expected_coords.size() == 0)
      $display("hit_polar_coords_delta_phi_tb: clean");
    else
      $display("hit_polar_coords_delta_phi_tb: errors");
    $finish;
  end
endmodule
